>>> src/tts_pkg.sv
// Package for the timed table sequencer: item and result structs, table
// entry layout, mode codes and register map.
// No dependencies; compiled before every other file of the block.
package tts_pkg;

    // Fixed field widths
    localparam int TIME_BITS    = 16;
    localparam int COMMAND_BITS = 8;
    localparam int STEP_BITS    = 4;

    // Item modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // Register map (byte addresses)
    localparam int         REG_ADDR_BITS      = 3;
    localparam logic [2:0] ADDR_TABLE_ENABLED = 3'd0;

    // Input item
    typedef struct packed {
        logic [1:0]              mode;
        logic [TIME_BITS-1:0]    now_time;
        logic [STEP_BITS-1:0]    entry_index;
        logic [TIME_BITS-1:0]    entry_wait;
        logic [COMMAND_BITS-1:0] entry_command;
        logic [STEP_BITS-1:0]    entry_next;
        logic [STEP_BITS-1:0]    start_step;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic                    fired;
        logic [COMMAND_BITS-1:0] command_out;
        logic [STEP_BITS-1:0]    step_now;
    } out_item_t;

    // One step table entry
    typedef struct packed {
        logic [TIME_BITS-1:0]    delay;
        logic [COMMAND_BITS-1:0] command;
        logic [STEP_BITS-1:0]    next_step;
    } entry_t;

    // Table write request
    typedef struct packed {
        logic                 en;
        logic [STEP_BITS-1:0] idx;
        entry_t               data;
    } tbl_wr_t;

endpackage

>>> src/tts_table.sv
// Step table memory with one write and one registered read per cycle.
// Write data is forwarded to the read port when both hit the same entry.
// Depends on tts_pkg.
module tts_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              clk,
    input  tts_pkg::tbl_wr_t                  wr,
    input  logic [tts_pkg::STEP_BITS-1:0]     rd_step,
    output tts_pkg::entry_t                   rd_entry
);
    import tts_pkg::*;

    localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
    localparam int IDX_BITS  = (ADDR_BITS > STEP_BITS) ? ADDR_BITS : STEP_BITS;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_entry_reg;

    logic [IDX_BITS-1:0]  wr_idx_ext;
    logic [IDX_BITS-1:0]  rd_idx_ext;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_in_range;
    logic                 rd_in_range;

    // Index decode; steps beyond the table read as an all-zero entry
    assign wr_idx_ext  = IDX_BITS'(wr.idx);
    assign rd_idx_ext  = IDX_BITS'(rd_step);
    assign wr_addr     = wr_idx_ext[ADDR_BITS-1:0];
    assign rd_addr     = rd_idx_ext[ADDR_BITS-1:0];
    assign wr_in_range = 32'(wr.idx) < 32'(TABLE_DEPTH);
    assign rd_in_range = 32'(rd_step) < 32'(TABLE_DEPTH);

    // Memory write and registered read with write-through forwarding
    always_ff @(posedge clk)
    begin
        if (wr.en && wr_in_range)
        begin
            mem[wr_addr] <= wr.data;
        end
        if (!rd_in_range)
        begin
            rd_entry_reg <= '0;
        end
        else if (wr.en && (wr.idx == rd_step))
        begin
            rd_entry_reg <= wr.data;
        end
        else
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

>>> src/timed_table_sequencer.sv
// Timed table sequencer top level: APB register, step state and result register.
// Depends on tts_pkg and tts_table.
//
// Walks a step table in time. A write item stores an entry (wait, command,
// next step), a start item enters a step and restarts the timer, and a tick
// item fires when now_time minus the start time (modulo 2^16) reaches the
// current wait: it emits the command of the step left, loads that step's wait
// and moves to its next step. Every item gives exactly one result, held in an
// output register from the cycle after the item is taken. The block takes one item
// per cycle as long as the result side keeps up: the table is read every cycle
// at the step the current item leaves the sequencer in, so the entry a tick
// needs is always waiting in the table's read register. No clearing pass
// runs after reset; table entries must be written before a tick reads them.
// table_enabled (byte address 0) gates ticks; start and write items act anyway.
module timed_table_sequencer #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tts_pkg::REG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Item channel
    input  logic                              item_valid,
    output logic                              item_ready,
    input  tts_pkg::in_item_t                 item,
    // Result channel
    output logic                              result_valid,
    input  logic                              result_ready,
    output tts_pkg::out_item_t                result
);
    import tts_pkg::*;

    logic                    table_enabled_reg;
    logic [STEP_BITS-1:0]    current_step_reg;
    logic [STEP_BITS-1:0]    current_step_next;
    logic [TIME_BITS-1:0]    start_time_reg;
    logic [TIME_BITS-1:0]    start_time_next;
    logic [TIME_BITS-1:0]    wait_time_reg;
    logic [TIME_BITS-1:0]    wait_time_next;
    logic                    result_valid_reg;
    out_item_t               result_reg;
    out_item_t               result_next;

    logic                    accept;
    logic                    cfg_write;
    logic                    is_start;
    logic                    fire;
    logic [TIME_BITS-1:0]    elapsed;
    entry_t                  cur_entry;
    tbl_wr_t                 tbl_wr;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_TABLE_ENABLED);

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_TABLE_ENABLED)
        begin
            prdata[0] = table_enabled_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_enabled_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            table_enabled_reg <= pwdata[0];
        end
    end

    // Handshake: take an item whenever the result register frees up
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    // Step table; read address is the step after this cycle's update
    assign tbl_wr.en   = accept && (item.mode == MODE_WRITE);
    assign tbl_wr.idx  = item.entry_index;
    assign tbl_wr.data = '{delay:     item.entry_wait,
                           command:   item.entry_command,
                           next_step: item.entry_next};

    tts_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .wr       (tbl_wr),
        .rd_step  (current_step_next),
        .rd_entry (cur_entry)
    );

    // Tick decision and state update
    assign elapsed  = item.now_time - start_time_reg;
    assign is_start = accept && (item.mode == MODE_START);
    assign fire     = accept && (item.mode == MODE_TICK) && table_enabled_reg
                      && (elapsed >= wait_time_reg);

    always_comb
    begin
        current_step_next = current_step_reg;
        start_time_next   = start_time_reg;
        wait_time_next    = wait_time_reg;
        if (fire)
        begin
            current_step_next = cur_entry.next_step;
            start_time_next   = item.now_time;
            wait_time_next    = cur_entry.delay;
        end
        else if (is_start)
        begin
            current_step_next = item.start_step;
            start_time_next   = item.now_time;
            wait_time_next    = '0;
        end
        result_next.fired       = fire;
        result_next.command_out = fire ? cur_entry.command : '0;
        result_next.step_now    = current_step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_step_reg <= '0;
            start_time_reg   <= '0;
            wait_time_reg    <= '0;
        end
        else
        begin
            current_step_reg <= current_step_next;
            start_time_reg   <= start_time_next;
            wait_time_reg    <= wait_time_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> src/tts_checker.sv
// Port-level checks for the timed table sequencer, bound to its top level.
// Depends on tts_pkg and timed_table_sequencer.
module tts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input tts_pkg::in_item_t   item,
    input logic                result_valid,
    input logic                result_ready,
    input tts_pkg::out_item_t  result
);
    import tts_pkg::*;

    // Every taken item shows a result on the next cycle
    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> result_valid)
        else $error("no result after an accepted item");

    // An empty result register never stalls the item side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("item side stalled with empty result register");

    // Only ticks can fire
    a_non_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.mode != MODE_TICK) |=> !result.fired)
        else $error("write, start or unused item fired");

    // No command without a transition
    a_cmd_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.fired |-> (result.command_out == '0))
        else $error("command reported without a transition");

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

endmodule

bind timed_table_sequencer tts_checker u_tts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
